### hdl/bmfa_pkg.sv
// Shared constants, codes and types of the first-fit bitmap allocator.
`timescale 1ns / 1ps
package bmfa_pkg;

    localparam int MAP_BITS       = 1024;
    localparam int WORD_BITS      = 32;
    localparam int NWORDS         = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int STEP_BITS      = 8;
    localparam int STEPS_PER_WORD = WORD_BITS / STEP_BITS;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int STAT_W = 2;
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int ADDR_W = $clog2(NWORDS);
    localparam int SUB_W  = $clog2(STEPS_PER_WORD);

    localparam logic [CMD_W-1:0] CMD_SET        = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND_FIRST = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND_RUN   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_SET   = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [CNT_W-1:0] run;
        logic [IDX_W-1:0] first;
    } t_step;

endpackage

### hdl/bmfa_in_if.sv
// Command channel of the allocator.
`timescale 1ns / 1ps
interface bmfa_in_if;
    import bmfa_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] bit_index;
    logic [CNT_W-1:0] run_length;

    modport source (output valid, command, bit_index, run_length, input ready);
    modport sink   (input valid, command, bit_index, run_length, output ready);
endinterface

### hdl/bmfa_out_if.sv
// Result channel of the allocator.
`timescale 1ns / 1ps
interface bmfa_out_if;
    import bmfa_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  found_index;
    logic [CNT_W-1:0]  used_count;

    modport source (output valid, status, found_index, used_count, input ready);
    modport sink   (input valid, status, found_index, used_count, output ready);
endinterface

### hdl/bmfa_cfg_if.sv
// Write channel of the map size register.
`timescale 1ns / 1ps
interface bmfa_cfg_if;
    import bmfa_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hdl/bmfa_step.sv
// Run search unit: advances the free-run tracker over one slice of the bitmap.
`timescale 1ns / 1ps
module bmfa_step (
    input  logic [bmfa_pkg::STEP_BITS-1:0] i_bits,
    input  logic [bmfa_pkg::CNT_W-1:0]     i_pos,
    input  logic [bmfa_pkg::CNT_W-1:0]     i_run,
    input  logic [bmfa_pkg::IDX_W-1:0]     i_first,
    input  logic [bmfa_pkg::CNT_W-1:0]     i_len,
    input  logic [bmfa_pkg::CNT_W-1:0]     i_lim,
    output bmfa_pkg::t_step                o_res
);
    import bmfa_pkg::*;

    always_comb begin
        logic [CNT_W:0] p;
        o_res.done  = 1'b0;
        o_res.found = 1'b0;
        o_res.run   = i_run;
        o_res.first = i_first;
        for (int k = 0; k < STEP_BITS; k++) begin
            p = {1'b0, i_pos} + (CNT_W+1)'(k);
            if (!o_res.done) begin
                if (p >= {1'b0, i_lim}) begin
                    // past the bound: the search ends empty
                    o_res.done = 1'b1;
                end else if (i_bits[k]) begin
                    o_res.run = '0;
                end else begin
                    if (o_res.run == '0) begin
                        o_res.first = p[IDX_W-1:0];
                    end
                    o_res.run = o_res.run + CNT_W'(1);
                    if (o_res.run >= i_len) begin
                        o_res.done  = 1'b1;
                        o_res.found = 1'b1;
                    end
                end
            end
        end
    end

endmodule

### hdl/bitmap_first_fit_allocator.sv
// Top level of the first-fit bitmap allocator.
//
// Commands arrive on i_cmd (valid/ready); each gives exactly one result on
// o_res. i_cfg writes map_size (always ready); write it only while idle.
// Set and clear read the occupancy word, modify it and write it back,
// going through the read and execute states to the done state. A set or
// clear whose index is out of range skips the memory and goes to done.
// Searches walk the store word by word and each word in 8-bit slices through
// one run search unit, one slice per cycle, with the next word prefetched
// from the word memory while the current one is scanned. A search ends at
// the slice where the run is found or the bound is met; the longest one
// scans every word and meets the bound past the last one.
// i_cmd.ready is high only while the sequencer is idle; one command at a time.
// The result register holds a finished result while o_res is stalled, and a
// new command may be accepted meanwhile; the sequencer then waits in its done
// state until the result register frees up.
// Reset (synchronous, active low) clears the word valid flags, which makes
// the whole bitmap read as free, zeroes the used count and sets map_size to
// 1024. No clearing pass is needed.
`timescale 1ns / 1ps
module bitmap_first_fit_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmfa_cfg_if.sink   i_cfg,
    bmfa_in_if.sink    i_cmd,
    bmfa_out_if.source o_res
);
    import bmfa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]           r_state;
    logic [CNT_W-1:0]     r_map_size;
    logic [CMD_W-1:0]     r_cmd;
    logic [IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_len;
    logic [CNT_W-1:0]     r_lim;
    logic [ADDR_W-1:0]    r_waddr;
    logic [WORD_BITS-1:0] r_mem [NWORDS];
    logic [NWORDS-1:0]    r_wvld;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic [WORD_BITS-1:0] r_word;
    logic [SUB_W-1:0]     r_sub;
    logic [CNT_W-1:0]     r_pos;
    logic [CNT_W-1:0]     r_run;
    logic [IDX_W-1:0]     r_first;
    logic [CNT_W-1:0]     r_cnt;
    logic [STAT_W-1:0]    r_status;
    logic [IDX_W-1:0]     r_found;
    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_out_status;
    logic [IDX_W-1:0]     r_out_found;
    logic [CNT_W-1:0]     r_out_count;

    logic                 in_acc;
    logic                 out_load;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 bit_used;
    logic                 mem_we;
    logic [WORD_BITS-1:0] n_word;
    logic [CNT_W-1:0]     n_cnt;
    logic [STAT_W-1:0]    n_status;
    logic [CNT_W-1:0]     n_lim;
    t_step                step;

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign in_acc      = i_cmd.valid && i_cmd.ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.found_index = r_out_found;
    assign o_res.used_count  = r_out_count;

    assign n_lim = (r_map_size > CNT_W'(MAP_BITS)) ? CNT_W'(MAP_BITS) : r_map_size;

    // words never written read as free
    assign cur_word = r_rd_vld ? r_rd_data : '0;
    assign bit_mask = WORD_BITS'(1) << r_idx[BIT_W-1:0];
    assign bit_used = (cur_word & bit_mask) != '0;

    always_comb begin
        n_word   = cur_word;
        n_cnt    = r_cnt;
        n_status = ST_OK;
        mem_we   = 1'b0;
        if (r_cmd == CMD_SET) begin
            if (!bit_used) begin
                n_word = cur_word | bit_mask;
                n_cnt  = r_cnt + CNT_W'(1);
                mem_we = 1'b1;
            end
        end else if (bit_used) begin
            n_word = cur_word & ~bit_mask;
            n_cnt  = r_cnt - CNT_W'(1);
            mem_we = 1'b1;
        end else begin
            n_status = ST_NOT_SET;
        end
    end

    bmfa_step u_step (
        .i_bits  (r_word[STEP_BITS-1:0]),
        .i_pos   (r_pos),
        .i_run   (r_run),
        .i_first (r_first),
        .i_len   (r_len),
        .i_lim   (r_lim),
        .o_res   (step)
    );

    // word memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EXEC) && (r_cmd == CMD_SET || r_cmd == CMD_CLEAR) && mem_we) begin
            r_mem[r_waddr] <= n_word;
        end
        r_rd_data <= r_mem[r_waddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_wvld[r_waddr];
            if ((r_state == S_EXEC) && (r_cmd == CMD_SET || r_cmd == CMD_CLEAR) && mem_we) begin
                r_wvld[r_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_size <= CNT_W'(MAP_BITS);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_map_size <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= i_cmd.command;
                        r_idx   <= i_cmd.bit_index;
                        r_lim   <= n_lim;
                        r_len   <= (i_cmd.command == CMD_FIND_FIRST || i_cmd.run_length == '0)
                                   ? CNT_W'(1) : i_cmd.run_length;
                        r_pos   <= '0;
                        r_run   <= '0;
                        r_first <= '0;
                        r_sub   <= '0;
                        r_found <= '0;
                        if (i_cmd.command == CMD_SET || i_cmd.command == CMD_CLEAR) begin
                            r_waddr <= i_cmd.bit_index[IDX_W-1:BIT_W];
                            if ({1'b0, i_cmd.bit_index} >= n_lim) begin
                                r_status <= ST_RANGE;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_RD;
                            end
                        end else begin
                            r_waddr <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (r_cmd == CMD_SET || r_cmd == CMD_CLEAR) begin
                        r_cnt    <= n_cnt;
                        r_status <= n_status;
                        r_state  <= S_DONE;
                    end else begin
                        // load the word and prefetch the next one
                        r_word  <= cur_word;
                        r_waddr <= r_waddr + ADDR_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_run   <= step.run;
                    r_first <= step.first;
                    r_pos   <= r_pos + CNT_W'(STEP_BITS);
                    r_word  <= r_word >> STEP_BITS;
                    if (step.done) begin
                        r_status <= step.found ? ST_OK : ST_NOT_FOUND;
                        r_found  <= step.found ? step.first : '0;
                        r_state  <= S_DONE;
                    end else if (r_sub == SUB_W'(STEPS_PER_WORD - 1)) begin
                        r_word  <= cur_word;
                        r_waddr <= r_waddr + ADDR_W'(1);
                        r_sub   <= '0;
                    end else begin
                        r_sub <= r_sub + SUB_W'(1);
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_count  <= r_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAP_BITS))
        else $error("used count above map capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_cmd.ready)
        else $error("command accepted while sequencer busy");

    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status != ST_OK |-> o_res.found_index == '0)
        else $error("found index set on a failed command");

    a_set_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && (r_cmd == CMD_SET) |=> r_status == ST_OK)
        else $error("set produced an error status");

endmodule
